// ----- src/msq_pkg.sv -----
// msq_pkg: request/response types, codes and widths for the multicast subscriber queue.
// Used by msq_cfg and multicast_subscriber_queue; no dependencies.
package msq_pkg;

    localparam int OP_W     = 3;
    localparam int SUB_W    = 4;
    localparam int MSG_W    = 32;
    localparam int STATUS_W = 3;
    localparam int AVAIL_W  = 5;
    localparam int CAP_W    = 5;
    localparam int APB_DW   = 32;
    localparam int PADDR_W  = 3;

    localparam logic [CAP_W-1:0]     CAP_RESET    = 5'd16;
    localparam logic [PADDR_W-3:0]   REG_CAPACITY = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_SUBSCRIBE   = 3'd0,
        OP_UNSUBSCRIBE = 3'd1,
        OP_GET         = 3'd2,
        OP_PUT         = 3'd3,
        OP_COUNT       = 3'd4,
        OP_REMOVE      = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_ALREADY   = 3'd1,
        ST_NOT_SUB   = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FULL      = 3'd4,
        ST_NOT_FOUND = 3'd5,
        ST_DROPPED   = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_GET_PTR,
        S_GET_DATA,
        S_COUNT,
        S_FIND_RD,
        S_FIND_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_ADJ_RD,
        S_ADJ_WR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_HEAD,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [SUB_W-1:0] subscriber;
        logic [MSG_W-1:0] message;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [MSG_W-1:0]    data;
        logic [AVAIL_W-1:0]  available;
    } rsp_t;

endpackage

// ----- src/msq_cfg.sv -----
// msq_cfg: APB-style register port holding the capacity register.
// Depends on msq_pkg.
module msq_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [msq_pkg::PADDR_W-1:0]  paddr,
    input  logic [msq_pkg::APB_DW-1:0]   pwdata,
    output logic [msq_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output logic [msq_pkg::CAP_W-1:0]    capacity
);
    import msq_pkg::*;

    logic [CAP_W-1:0] cap_reg;
    logic [CAP_W-1:0] cap_next;
    logic             hit;

    assign hit    = (paddr[PADDR_W-1:2] == REG_CAPACITY);
    assign pready = 1'b1;

    always_comb
    begin
        cap_next = cap_reg;
        if (psel && penable && pwrite && hit)
        begin
            cap_next = pwdata[CAP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    assign prdata   = hit ? APB_DW'(cap_reg) : '0;
    assign capacity = cap_reg;

endmodule

// ----- src/multicast_subscriber_queue.sv -----
// multicast_subscriber_queue: broadcast queue with a read pointer per subscriber.
// Depends on msq_pkg and msq_cfg.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | msq_pkg::req_t (op, subscriber, message)
//   rsp     | out       | rsp_valid / rsp_ready | msq_pkg::rsp_t (status, data, available)
//   apb     | in        | psel/penable, pready  | paddr, pwdata, prdata (capacity register)
//
// One request at a time; req_ready is high only in idle. Put, rejected and unknown
// requests go from decode straight to done; count and empty get first read the
// subscriber pointer; subscribe, unsubscribe and get end with a head rescan through the
// pointer memory read port. Remove searches the queue and, if found, does compaction,
// pointer fix-up and rescan. Reset clears control state only. A waiting response holds
// the next request in its done state; it does not block acceptance.
module multicast_subscriber_queue #(
    parameter int DEPTH       = 16,
    parameter int SUBSCRIBERS = 16,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  msq_pkg::req_t                req,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output msq_pkg::rsp_t                rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [msq_pkg::PADDR_W-1:0]  paddr,
    input  logic [msq_pkg::APB_DW-1:0]   pwdata,
    output logic [msq_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import msq_pkg::*;

    localparam int SEQ_MOD = 2 * DEPTH;
    localparam int PW      = $clog2(SEQ_MOD);
    localparam int IW      = $clog2(DEPTH);
    localparam int SW      = (SUBSCRIBERS > 1) ? $clog2(SUBSCRIBERS) : 1;
    localparam int SCW     = $clog2(SUBSCRIBERS + 1);
    localparam int DW      = DATA_WIDTH;

    function automatic logic [IW-1:0] idx_of(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        r = (p >= PW'(DEPTH)) ? p - PW'(DEPTH) : p;
        return r[IW-1:0];
    endfunction

    function automatic logic [PW-1:0] seq_inc(input logic [PW-1:0] p);
        return (p == PW'(SEQ_MOD - 1)) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] seq_dec(input logic [PW-1:0] p);
        return (p == '0) ? PW'(SEQ_MOD - 1) : p - PW'(1);
    endfunction

    logic [CAP_W-1:0] capacity;

    msq_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    // control state
    state_t                 state_reg, state_next;
    logic [PW-1:0]          head_reg, head_next;
    logic [PW-1:0]          tail_reg, tail_next;
    logic [SUBSCRIBERS-1:0] active_reg, active_next;
    logic                   rsp_valid_reg, rsp_valid_next;

    // working registers
    req_t                   req_reg, req_next;
    status_t                status_reg, status_next;
    logic [MSG_W-1:0]       data_reg, data_next;
    logic [AVAIL_W-1:0]     avail_reg, avail_next;
    logic [PW-1:0]          far_reg, far_next;
    logic [SCW-1:0]         scnt_reg, scnt_next;
    logic [PW-1:0]          k_reg, k_next;
    logic [PW-1:0]          found_reg, found_next;
    logic [PW-1:0]          occ_reg, occ_next;
    logic [PW-1:0]          ptr_reg, ptr_next;
    rsp_t                   rsp_reg, rsp_next;

    // message and pointer memories
    logic [DW-1:0]          ent_mem [DEPTH];
    logic [DW-1:0]          ent_rdata_reg;
    logic                   ent_we;
    logic [IW-1:0]          ent_waddr, ent_raddr;
    logic [DW-1:0]          ent_wdata;

    logic [PW-1:0]          rp_mem [SUBSCRIBERS];
    logic [PW-1:0]          rp_rdata_reg;
    logic                   rp_we;
    logic [SW-1:0]          rp_waddr, rp_raddr;
    logic [PW-1:0]          rp_wdata;

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        ent_rdata_reg <= ent_mem[ent_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rp_we)
        begin
            rp_mem[rp_waddr] <= rp_wdata;
        end
        rp_rdata_reg <= rp_mem[rp_raddr];
    end

    // shared modular distance unit: (dist_to - dist_from) mod SEQ_MOD
    logic [PW-1:0] dist_from, dist_to, dist_out;
    logic [PW:0]   dist_raw;

    always_comb
    begin
        dist_from = head_reg;
        dist_to   = tail_reg;
        unique case (state_reg)
            S_GET_PTR,
            S_COUNT,
            S_SCAN_CHK:
            begin
                dist_from = rp_rdata_reg;
            end
            S_ADJ_WR:
            begin
                dist_to = rp_rdata_reg;
            end
            S_HEAD:
            begin
                dist_from = far_reg;
            end
            default:
            begin
            end
        endcase
        dist_raw = {1'b0, dist_to} - {1'b0, dist_from};
        if (dist_to < dist_from)
        begin
            dist_raw = dist_raw + (PW+1)'(SEQ_MOD);
        end
        dist_out = dist_raw[PW-1:0];
    end

    logic [SW-1:0]  sub_idx;
    logic           sub_ok;
    logic [SW-1:0]  scan_idx;
    logic [DW-1:0]  msg_cmp;
    logic           any_active;

    assign sub_idx    = SW'(req_reg.subscriber);
    assign sub_ok     = (32'(req_reg.subscriber) < 32'(SUBSCRIBERS));
    assign scan_idx   = scnt_reg[SW-1:0];
    assign msg_cmp    = DW'(req_reg.message);
    assign any_active = |active_reg;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        active_next    = active_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        req_next       = req_reg;
        status_next    = status_reg;
        data_next      = data_reg;
        avail_next     = avail_reg;
        far_next       = far_reg;
        scnt_next      = scnt_reg;
        k_next         = k_reg;
        found_next     = found_reg;
        occ_next       = occ_reg;
        ptr_next       = ptr_reg;
        rsp_next       = rsp_reg;
        ent_we         = 1'b0;
        ent_waddr      = idx_of(tail_reg);
        ent_wdata      = msg_cmp;
        ent_raddr      = idx_of(ptr_reg);
        rp_we          = 1'b0;
        rp_waddr       = sub_idx;
        rp_wdata       = tail_reg;
        rp_raddr       = sub_idx;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next    = req;
                    status_next = ST_OK;
                    data_next   = '0;
                    avail_next  = '0;
                    state_next  = S_DECODE;
                end
            end

            S_DECODE:
            begin
                far_next  = '0;
                scnt_next = '0;
                case (req_reg.op)
                    OP_SUBSCRIBE:
                    begin
                        if (!sub_ok)
                        begin
                            status_next = ST_NOT_SUB;
                            state_next  = S_DONE;
                        end
                        else if (active_reg[sub_idx])
                        begin
                            status_next = ST_ALREADY;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            active_next[sub_idx] = 1'b1;
                            rp_we                = 1'b1;
                            state_next           = S_SCAN_RD;
                        end
                    end
                    OP_UNSUBSCRIBE:
                    begin
                        if (!sub_ok || !active_reg[sub_idx])
                        begin
                            status_next = ST_NOT_SUB;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            active_next[sub_idx] = 1'b0;
                            state_next           = S_SCAN_RD;
                        end
                    end
                    OP_GET,
                    OP_COUNT:
                    begin
                        if (!sub_ok || !active_reg[sub_idx])
                        begin
                            status_next = ST_NOT_SUB;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = (req_reg.op == OP_GET) ? S_GET_PTR : S_COUNT;
                        end
                    end
                    OP_PUT:
                    begin
                        state_next = S_DONE;
                        if (!any_active)
                        begin
                            status_next = ST_DROPPED;
                        end
                        else if ((32'(dist_out) >= 32'(capacity)) ||
                                 (32'(dist_out) >= 32'(DEPTH)))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ent_we    = 1'b1;
                            tail_next = seq_inc(tail_reg);
                        end
                    end
                    OP_REMOVE:
                    begin
                        occ_next   = dist_out;
                        ptr_next   = head_reg;
                        k_next     = '0;
                        state_next = S_FIND_RD;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_GET_PTR:
            begin
                if (rp_rdata_reg == tail_reg)
                begin
                    status_next = ST_EMPTY;
                    state_next  = S_DONE;
                end
                else
                begin
                    ent_raddr  = idx_of(rp_rdata_reg);
                    rp_we      = 1'b1;
                    rp_wdata   = seq_inc(rp_rdata_reg);
                    state_next = S_GET_DATA;
                end
            end

            S_GET_DATA:
            begin
                data_next  = MSG_W'(ent_rdata_reg);
                state_next = S_SCAN_RD;
            end

            S_COUNT:
            begin
                avail_next = AVAIL_W'(dist_out);
                state_next = S_DONE;
            end

            S_FIND_RD:
            begin
                if (k_reg == occ_reg)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_FIND_CMP;
                end
            end

            S_FIND_CMP:
            begin
                if (ent_rdata_reg == msg_cmp)
                begin
                    found_next = k_reg;
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    k_next     = k_reg + PW'(1);
                    ptr_next   = seq_inc(ptr_reg);
                    state_next = S_FIND_RD;
                end
            end

            S_SHIFT_RD:
            begin
                if ((k_reg + PW'(1)) < occ_reg)
                begin
                    ent_raddr  = idx_of(seq_inc(ptr_reg));
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    scnt_next  = '0;
                    state_next = S_ADJ_RD;
                end
            end

            S_SHIFT_WR:
            begin
                ent_we     = 1'b1;
                ent_waddr  = idx_of(ptr_reg);
                ent_wdata  = ent_rdata_reg;
                ptr_next   = seq_inc(ptr_reg);
                k_next     = k_reg + PW'(1);
                state_next = S_SHIFT_RD;
            end

            S_ADJ_RD:
            begin
                if (scnt_reg == SCW'(SUBSCRIBERS))
                begin
                    tail_next  = seq_dec(tail_reg);
                    scnt_next  = '0;
                    far_next   = '0;
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    rp_raddr   = scan_idx;
                    state_next = S_ADJ_WR;
                end
            end

            S_ADJ_WR:
            begin
                if (active_reg[scan_idx] && (dist_out > found_reg))
                begin
                    rp_we    = 1'b1;
                    rp_waddr = scan_idx;
                    rp_wdata = seq_dec(rp_rdata_reg);
                end
                scnt_next  = scnt_reg + SCW'(1);
                state_next = S_ADJ_RD;
            end

            S_SCAN_RD:
            begin
                if (scnt_reg == SCW'(SUBSCRIBERS))
                begin
                    state_next = S_HEAD;
                end
                else
                begin
                    rp_raddr   = scan_idx;
                    state_next = S_SCAN_CHK;
                end
            end

            S_SCAN_CHK:
            begin
                if (active_reg[scan_idx] && (dist_out > far_reg))
                begin
                    far_next = dist_out;
                end
                scnt_next  = scnt_reg + SCW'(1);
                state_next = S_SCAN_RD;
            end

            S_HEAD:
            begin
                // tail - far
                head_next  = dist_out;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.status    = status_reg;
                    rsp_next.data      = data_reg;
                    rsp_next.available = avail_reg;
                    rsp_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            active_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            active_reg    <= active_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        status_reg <= status_next;
        data_reg   <= data_next;
        avail_reg  <= avail_next;
        far_reg    <= far_next;
        scnt_reg   <= scnt_next;
        k_reg      <= k_next;
        found_reg  <= found_next;
        occ_reg    <= occ_next;
        ptr_reg    <= ptr_next;
        rsp_reg    <= rsp_next;
    end

endmodule

// ----- tb/sv/multicast_subscriber_queue_test.sv -----
`timescale 1ns / 1ps
// multicast_subscriber_queue_test: self-checking testbench for multicast_subscriber_queue.
// A scoreboard class predicts every response; tasks drive the request and APB ports, a loop rsp_ready.
// Depends on msq_pkg and multicast_subscriber_queue.
module multicast_subscriber_queue_test;
    import msq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int SUBSCRIBERS  = 16;
    localparam int SEQ_W        = $clog2(2 * DEPTH);
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int END_CYCLES   = 100;
    localparam int STALL_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 10;
    localparam int RECENT_N     = 8;
    localparam int RECENT_W     = $clog2(RECENT_N);

    localparam logic [OP_W-1:0]    OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0]    OP_RSVD_7 = 3'd7;
    localparam logic [PADDR_W-1:0] CAP_ADDR  = {REG_CAPACITY, 2'b00};

    class msq_scoreboard;
        logic [MSG_W-1:0] entries [DEPTH];
        logic [SEQ_W-1:0] rd_seq [SUBSCRIBERS];
        bit               active [SUBSCRIBERS];
        logic [SEQ_W-1:0] head_seq;
        logic [SEQ_W-1:0] tail_seq;
        logic [CAP_W-1:0] capacity;
        rsp_t             pending_rsp [$];
        int unsigned      mismatches;

        function new();
            for (int i = 0; i < DEPTH; i++)
                entries[i] = '0;
            for (int s = 0; s < SUBSCRIBERS; s++)
            begin
                rd_seq[s] = '0;
                active[s] = 1'b0;
            end
            head_seq   = '0;
            tail_seq   = '0;
            capacity   = CAP_RESET;
            mismatches = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            capacity = value;
        endfunction

        function logic [IDX_W-1:0] slot(logic [SEQ_W-1:0] base, int offset);
            logic [SEQ_W-1:0] p;
            p = base + SEQ_W'(offset);
            return p[IDX_W-1:0];
        endfunction

        // head = oldest read pointer among active subscribers, tail when none
        function void update_head();
            logic [SEQ_W-1:0] far;
            logic [SEQ_W-1:0] span;
            far = '0;
            for (int s = 0; s < SUBSCRIBERS; s++)
                if (active[s])
                begin
                    span = tail_seq - rd_seq[s];
                    if (span > far)
                        far = span;
                end
            head_seq = tail_seq - far;
        endfunction

        function void log_request(req_t r);
            rsp_t             x;
            logic [SEQ_W-1:0] occ;
            logic [SEQ_W-1:0] found;
            logic [SEQ_W-1:0] span;
            logic [CAP_W-1:0] eff_cap;
            logic [SUB_W-1:0] sub;
            bit               hit;
            bit               any_sub;
            x       = '0;
            sub     = r.subscriber;
            occ     = tail_seq - head_seq;
            eff_cap = (capacity > DEPTH) ? CAP_W'(DEPTH) : capacity;
            any_sub = 1'b0;
            for (int s = 0; s < SUBSCRIBERS; s++)
                if (active[s])
                    any_sub = 1'b1;
            case (r.op)
                OP_SUBSCRIBE:
                    if (active[sub])
                        x.status = ST_ALREADY;
                    else
                    begin
                        active[sub] = 1'b1;
                        rd_seq[sub] = tail_seq;
                        update_head();
                    end
                OP_UNSUBSCRIBE:
                    if (!active[sub])
                        x.status = ST_NOT_SUB;
                    else
                    begin
                        active[sub] = 1'b0;
                        update_head();
                    end
                OP_GET:
                    if (!active[sub])
                        x.status = ST_NOT_SUB;
                    else if (rd_seq[sub] == tail_seq)
                        x.status = ST_EMPTY;
                    else
                    begin
                        x.data      = entries[rd_seq[sub][IDX_W-1:0]];
                        rd_seq[sub] = rd_seq[sub] + SEQ_W'(1);
                        update_head();
                    end
                OP_PUT:
                    if (!any_sub)
                        x.status = ST_DROPPED;
                    else if (occ >= eff_cap)
                        x.status = ST_FULL;
                    else
                    begin
                        entries[tail_seq[IDX_W-1:0]] = r.message;
                        tail_seq = tail_seq + SEQ_W'(1);
                    end
                OP_COUNT:
                    if (!active[sub])
                        x.status = ST_NOT_SUB;
                    else
                        x.available = AVAIL_W'(tail_seq - rd_seq[sub]);
                OP_REMOVE:
                begin
                    hit   = 1'b0;
                    found = '0;
                    for (int k = 0; k < int'(occ); k++)
                        if (!hit && entries[slot(head_seq, k)] == r.message)
                        begin
                            hit   = 1'b1;
                            found = SEQ_W'(k);
                        end
                    if (!hit)
                        x.status = ST_NOT_FOUND;
                    else
                    begin
                        for (int k = int'(found); k + 1 < int'(occ); k++)
                            entries[slot(head_seq, k)] = entries[slot(head_seq, k + 1)];
                        for (int s = 0; s < SUBSCRIBERS; s++)
                        begin
                            span = rd_seq[s] - head_seq;
                            if (active[s] && span > found)
                                rd_seq[s] = rd_seq[s] - SEQ_W'(1);
                        end
                        tail_seq = tail_seq - SEQ_W'(1);
                        update_head();
                    end
                end
                default: ;
            endcase
            pending_rsp.push_back(x);
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected response status %0d data %h available %0d",
                             $time, got.status, got.data, got.available);
                return;
            end
            want = pending_rsp.pop_front();
            if (got.status !== want.status || got.data !== want.data ||
                got.available !== want.available)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: exp st %0d data %h avail %0d, got st %0d data %h avail %0d",
                             $time, want.status, want.data, want.available,
                             got.status, got.data, got.available);
            end
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    req_t                req       = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    rsp_t                rsp;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [PADDR_W-1:0]  paddr     = '0;
    logic [APB_DW-1:0]   pwdata    = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    msq_scoreboard       sb = new();
    bit                  steady_flow  = 1'b0;
    bit                  hold_request = 1'b0;
    int unsigned         idle_cycles  = 0;
    logic [MSG_W-1:0]    recent_msg [RECENT_N] = '{default: '0};
    int unsigned         recent_idx   = 0;

    multicast_subscriber_queue i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // response side: random stalls, one long hold-off on request
    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            int unsigned stall;
            if (hold_request)
            begin
                stall        = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else
                stall = steady_flow ? 0 : $urandom_range(0, 9);
            if (stall != 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
            sb.check_response(rsp);
        end
    end

    task automatic send_request(input req_t r);
        int unsigned gap;
        gap = steady_flow ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (!req_ready);
        sb.log_request(r);
    endtask

    task automatic send_op(input logic [OP_W-1:0] op, input logic [SUB_W-1:0] sub,
                           input logic [MSG_W-1:0] msg);
        req_t r;
        r.op         = op;
        r.subscriber = sub;
        r.message    = msg;
        send_request(r);
    endtask

    task automatic wait_drained();
        while (sb.pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_capacity(value);
    endtask

    // small subscriber pool so pointers overlap; removes mostly target stored values
    function automatic req_t random_request();
        req_t        r;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0)
            r.subscriber = SUB_W'($urandom);
        else
            r.subscriber = SUB_W'($urandom_range(0, 3));
        r.message = $urandom;
        if ($urandom_range(0, 3) == 0)
            r.message = recent_msg[RECENT_W'($urandom_range(0, RECENT_N - 1))];
        if (pick < 10)
            r.op = OP_SUBSCRIBE;
        else if (pick < 16)
            r.op = OP_UNSUBSCRIBE;
        else if (pick < 48)
            r.op = OP_GET;
        else if (pick < 76)
            r.op = OP_PUT;
        else if (pick < 86)
            r.op = OP_COUNT;
        else if (pick < 97)
        begin
            r.op = OP_REMOVE;
            if ($urandom_range(0, 2) != 0)
                r.message = recent_msg[RECENT_W'($urandom_range(0, RECENT_N - 1))];
        end
        else
            r.op = ($urandom_range(0, 1) == 0) ? OP_RSVD_6 : OP_RSVD_7;
        if (r.op == OP_PUT)
        begin
            recent_msg[RECENT_W'(recent_idx % RECENT_N)] = r.message;
            recent_idx++;
        end
        return r;
    endfunction

    task automatic run_phase(input logic [CAP_W-1:0] cap, input int unsigned count,
                             input bit steady, input bit hold);
        write_capacity(cap);
        steady_flow  = steady;
        hold_request = hold;
        repeat (count) send_request(random_request());
        req_valid <= 1'b0;
        wait_drained();
    endtask

    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);

        send_op(OP_GET, 4'd0, '0);
        send_op(OP_PUT, 4'd0, 32'hFFFF_FFFF);
        send_op(OP_UNSUBSCRIBE, 4'd15, '0);
        send_op(OP_COUNT, 4'd15, '0);
        send_op(OP_SUBSCRIBE, 4'd0, '0);
        send_op(OP_SUBSCRIBE, 4'd0, '0);
        send_op(OP_SUBSCRIBE, 4'd15, '0);
        send_op(OP_GET, 4'd0, '0);
        send_op(OP_PUT, 4'd0, 32'h0000_0000);
        send_op(OP_PUT, 4'd15, 32'hFFFF_FFFF);
        send_op(OP_PUT, 4'd0, 32'hA5A5_A5A5);
        send_op(OP_PUT, 4'd0, 32'h0000_0000);
        send_op(OP_COUNT, 4'd0, '0);
        send_op(OP_REMOVE, 4'd0, 32'h1234_5678);
        send_op(OP_REMOVE, 4'd0, 32'h0000_0000);
        send_op(OP_GET, 4'd0, '0);
        send_op(OP_COUNT, 4'd15, '0);
        send_op(OP_UNSUBSCRIBE, 4'd15, '0);
        send_op(OP_RSVD_6, 4'd15, 32'hFFFF_FFFF);
        send_op(OP_RSVD_7, 4'd0, '0);
        send_op(OP_GET, 4'd0, '0);
        send_op(OP_GET, 4'd0, '0);
        send_op(OP_GET, 4'd0, '0);
        send_op(OP_REMOVE, 4'd0, 32'h0000_0000);
        send_op(OP_UNSUBSCRIBE, 4'd0, '0);
        req_valid <= 1'b0;
        wait_drained();

        run_phase(CAP_RESET, 250, 1'b0, 1'b0);
        run_phase(CAP_W'(1), 150, 1'b0, 1'b0);
        run_phase(CAP_W'(31), 250, 1'b1, 1'b1);
        run_phase(CAP_W'(0), 40, 1'b0, 1'b0);
        run_phase(CAP_W'($urandom_range(2, 15)), 200, 1'b0, 1'b0);
        run_phase(CAP_W'(5), 200, 1'b1, 1'b0);
        run_phase(CAP_W'(DEPTH), 185, 1'b0, 1'b0);

        repeat (END_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_rsp.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/msq_pkg.sv
src/msq_cfg.sv
src/multicast_subscriber_queue.sv
tb/sv/multicast_subscriber_queue_test.sv
